>>> hdl/svpwm_pkg.sv
// Shared constants for the space vector PWM duty generator.
`timescale 1ns / 1ps

package svpwm_pkg;

	localparam int FRAC_BITS_DEF = 24;

	// floor(sqrt(3)/2 * 2^32)
	localparam logic [31:0] SQ3H_Q32 = 32'd3719550786;

	localparam int QUEUE_DEPTH = 4;

	localparam int DUTY_W = 25;

	// sector codes, bit weights 1 (beta), 2 and 4
	localparam logic [2:0] SEC_ZERO = 3'd0;
	localparam logic [2:0] SEC_1    = 3'd1;
	localparam logic [2:0] SEC_2    = 3'd2;
	localparam logic [2:0] SEC_3    = 3'd3;
	localparam logic [2:0] SEC_4    = 3'd4;
	localparam logic [2:0] SEC_5    = 3'd5;
	localparam logic [2:0] SEC_6    = 3'd6;
	localparam logic [2:0] SEC_7    = 3'd7;

endpackage

>>> hdl/space_vector_pwm_duty_top.sv
// Space vector PWM duty generator, top level.
`timescale 1ns / 1ps

// Takes one (v_alpha, v_beta) vector per cycle while in_ready is high, and
// returns three centered phase duties plus the sector code, one result per
// request, in order. Throughput is one request per clock while out_ready is
// high. A pipelined restoring divider rescales the active-vector times, one
// quotient bit per stage. A four-entry queue separates the multiply/sector
// front end from the divider back end so either side can stall independently.

module space_vector_pwm_duty_top #(
	parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] v_alpha,
	input  logic signed [31:0] v_beta,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [24:0]        duty_a,
	output logic [24:0]        duty_b,
	output logic [24:0]        duty_c,
	output logic [2:0]         sector
);

	localparam int TW = 66 - FRAC_BITS;
	localparam int FW = 3 + 2 * TW;

	logic                 f_valid, f_ready, b_valid, b_ready;
	logic [2:0]           f_sec;
	logic signed [TW-1:0] f_t1, f_t2;
	logic [FW-1:0]        b_data;

	svpwm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.v_alpha  (v_alpha),
		.v_beta   (v_beta),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_sector (f_sec),
		.q_t1     (f_t1),
		.q_t2     (f_t2)
	);

	svpwm_fifo #(.WIDTH(FW), .DEPTH(svpwm_pkg::QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_sec, f_t1, f_t2}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	svpwm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_sector  (b_data[FW-1 -: 3]),
		.q_t1      ($signed(b_data[2*TW-1 -: TW])),
		.q_t2      ($signed(b_data[TW-1:0])),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.duty_a    (duty_a),
		.duty_b    (duty_b),
		.duty_c    (duty_c),
		.sector    (sector)
	);

endmodule

>>> hdl/svpwm_front.sv
// Front end: sqrt3/2 multiply, sector decode and active-vector time selection.
`timescale 1ns / 1ps

module svpwm_front #(
	parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF,
	localparam int TW = 66 - FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   v_alpha,
	input  logic signed [31:0]   v_beta,
	output logic                 q_valid,
	input  logic                 q_ready,
	output logic [2:0]           q_sector,
	output logic signed [TW-1:0] q_t1,
	output logic signed [TW-1:0] q_t2
);

	localparam logic [31:0] K = svpwm_pkg::SQ3H_Q32 >> (32 - FRAC_BITS);

	logic                 v_s1, v_s2;
	logic signed [63:0]   p_s1;
	logic signed [31:0]   be_s1;
	logic [2:0]           sec_s2;
	logic signed [TW-1:0] t1_s2, t2_s2;

	logic                 adv;
	logic signed [32:0]   ks;
	logic signed [63:0]   prod;
	logic signed [63:0]   np;
	logic signed [32:0]   nbe;
	logic signed [TW-1:0] ka, nka, hb, nhb, x, y, z, s1, s2, t1, t2;
	logic [2:0]           sec;

	assign adv      = !v_s2 || q_ready;
	assign in_ready = adv;
	assign ks       = $signed({1'b0, K});
	assign prod     = ks * v_alpha;

	always_comb begin
		np  = -p_s1;
		nbe = -$signed({be_s1[31], be_s1});
		ka  = $signed({{2{p_s1[63]}}, p_s1[63:FRAC_BITS]});
		nka = $signed({{2{np[63]}}, np[63:FRAC_BITS]});
		hb  = $signed({{(TW - 31){be_s1[31]}}, be_s1[31:1]});
		nhb = $signed({{(TW - 32){nbe[32]}}, nbe[32:1]});
		x   = $signed({{(TW - 32){be_s1[31]}}, be_s1});
		y   = hb + ka;
		z   = hb - ka;
		s1  = nhb + ka;
		s2  = nhb + nka;
		sec = {s2 > 0, s1 > 0, be_s1 > 0};
		unique case (sec)
			svpwm_pkg::SEC_1: begin t1 = z;  t2 = y;  end
			svpwm_pkg::SEC_2: begin t1 = y;  t2 = -x; end
			svpwm_pkg::SEC_3: begin t1 = -z; t2 = x;  end
			svpwm_pkg::SEC_4: begin t1 = -x; t2 = z;  end
			svpwm_pkg::SEC_5: begin t1 = x;  t2 = -y; end
			svpwm_pkg::SEC_6: begin t1 = -y; t2 = -z; end
			default: begin t1 = '0; t2 = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1   <= prod;
			be_s1  <= v_beta;
			sec_s2 <= sec;
			t1_s2  <= t1;
			t2_s2  <= t2;
		end
	end

	assign q_valid  = v_s2;
	assign q_sector = sec_s2;
	assign q_t1     = t1_s2;
	assign q_t2     = t2_s2;

endmodule

>>> hdl/svpwm_fifo.sv
// Small request queue between the front end and the divider back end.
`timescale 1ns / 1ps

module svpwm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = svpwm_pkg::QUEUE_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             push, pop;

	assign wr_ready = cnt_q != (AW + 1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

>>> hdl/svpwm_back.sv
// Back end: overmodulation rescale (pipelined restoring divide) and duty build.
`timescale 1ns / 1ps

module svpwm_back #(
	parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF,
	localparam int TW = 66 - FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  logic [2:0]           q_sector,
	input  logic signed [TW-1:0] q_t1,
	input  logic signed [TW-1:0] q_t2,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [svpwm_pkg::DUTY_W-1:0] duty_a,
	output logic [svpwm_pkg::DUTY_W-1:0] duty_b,
	output logic [svpwm_pkg::DUTY_W-1:0] duty_c,
	output logic [2:0]           sector
);

	localparam int SW  = TW + 1;
	localparam int QW  = FRAC_BITS + 2;
	localparam int DW  = TW + 2;
	localparam int NST = FRAC_BITS + 2;
	localparam int OW  = svpwm_pkg::DUTY_W;
	localparam logic signed [SW-1:0] ONE_S  = SW'(64'd1 << FRAC_BITS);
	localparam logic signed [DW-1:0] ONE_D  = DW'(64'd1 << FRAC_BITS);
	localparam logic signed [DW-1:0] HALF_D = DW'(64'd1 << (FRAC_BITS - 1));

	logic                 vld_s [NST+1];
	logic [2:0]           sec_s [NST];
	logic signed [TW-1:0] t1_s  [NST];
	logic signed [TW-1:0] t2_s  [NST];
	logic [SW-1:0]        sum_s [NST];
	logic                 ovm_s [NST];
	logic                 n1_s  [NST];
	logic                 n2_s  [NST];
	logic [SW-1:0]        r1_s  [NST];
	logic [SW-1:0]        r2_s  [NST];
	logic [QW-1:0]        q1_s  [NST];
	logic [QW-1:0]        q2_s  [NST];

	logic                 adv;
	logic signed [SW-1:0] sum_in;
	logic [TW-1:0]        m1_in, m2_in;

	assign adv     = !vld_s[NST] || out_ready;
	assign q_ready = adv;

	always_comb begin
		sum_in = SW'(q_t1) + SW'(q_t2);
		m1_in  = q_t1[TW-1] ? TW'(-q_t1) : TW'(q_t1);
		m2_in  = q_t2[TW-1] ? TW'(-q_t2) : TW'(q_t2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NST; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= q_valid;
			for (int i = 1; i <= NST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s[0] <= q_sector;
			t1_s[0]  <= q_t1;
			t2_s[0]  <= q_t2;
			sum_s[0] <= sum_in;
			ovm_s[0] <= sum_in > ONE_S;
			n1_s[0]  <= q_t1[TW-1];
			n2_s[0]  <= q_t2[TW-1];
			r1_s[0]  <= {1'b0, m1_in};
			r2_s[0]  <= {1'b0, m2_in};
			q1_s[0]  <= '0;
			q2_s[0]  <= '0;
		end
	end

	// one quotient bit per stage; the first stage yields the integer bit
	for (genvar j = 1; j < NST; j++) begin : g_div
		logic [SW:0] ra, rb, dv;
		logic        ga, gb;

		always_comb begin
			if (j == 1) begin
				ra = {1'b0, r1_s[j-1]};
				rb = {1'b0, r2_s[j-1]};
			end else begin
				ra = {r1_s[j-1], 1'b0};
				rb = {r2_s[j-1], 1'b0};
			end
			dv = {1'b0, sum_s[j-1]};
			ga = ra >= dv;
			gb = rb >= dv;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sec_s[j] <= sec_s[j-1];
				t1_s[j]  <= t1_s[j-1];
				t2_s[j]  <= t2_s[j-1];
				sum_s[j] <= sum_s[j-1];
				ovm_s[j] <= ovm_s[j-1];
				n1_s[j]  <= n1_s[j-1];
				n2_s[j]  <= n2_s[j-1];
				r1_s[j]  <= ga ? SW'(ra - dv) : ra[SW-1:0];
				r2_s[j]  <= gb ? SW'(rb - dv) : rb[SW-1:0];
				q1_s[j]  <= {q1_s[j-1][QW-2:0], ga};
				q2_s[j]  <= {q2_s[j-1][QW-2:0], gb};
			end
		end
	end

	function automatic logic [OW-1:0] clamp(input logic signed [DW-1:0] d);
		logic signed [DW-1:0] c;
		begin
			if (d < 0) c = '0;
			else if (d > ONE_D) c = ONE_D;
			else c = d;
			clamp = c[OW-1:0];
		end
	endfunction

	logic signed [TW-1:0] qs1, qs2, tt1, tt2;
	logic signed [DW-1:0] e1, e2, base, b1, b2, da, db, dc;

	always_comb begin
		qs1  = $signed({{(TW - QW){1'b0}}, q1_s[NST-1]});
		qs2  = $signed({{(TW - QW){1'b0}}, q2_s[NST-1]});
		tt1  = ovm_s[NST-1] ? (n1_s[NST-1] ? -qs1 : qs1) : t1_s[NST-1];
		tt2  = ovm_s[NST-1] ? (n2_s[NST-1] ? -qs2 : qs2) : t2_s[NST-1];
		e1   = DW'(tt1);
		e2   = DW'(tt2);
		base = (ONE_D - e1 - e2) >>> 1;
		b1   = base + e1;
		b2   = b1 + e2;
		unique case (sec_s[NST-1])
			svpwm_pkg::SEC_1: begin da = b1;   db = base; dc = b2;   end
			svpwm_pkg::SEC_2: begin da = base; db = b2;   dc = b1;   end
			svpwm_pkg::SEC_3: begin da = base; db = b1;   dc = b2;   end
			svpwm_pkg::SEC_4: begin da = b2;   db = b1;   dc = base; end
			svpwm_pkg::SEC_5: begin da = b2;   db = base; dc = b1;   end
			svpwm_pkg::SEC_6: begin da = b1;   db = b2;   dc = base; end
			default: begin da = HALF_D; db = HALF_D; dc = HALF_D; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			duty_a <= clamp(da);
			duty_b <= clamp(db);
			duty_c <= clamp(dc);
			sector <= sec_s[NST-1];
		end
	end

	assign out_valid = vld_s[NST];

endmodule

>>> hdl/svpwm_chk.sv
// Port-level checker for the space vector PWM duty generator, with its bind.
`timescale 1ns / 1ps

module svpwm_chk #(
	parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] v_alpha,
	input logic [31:0] v_beta,
	input logic        out_valid,
	input logic        out_ready,
	input logic [24:0] duty_a,
	input logic [24:0] duty_b,
	input logic [24:0] duty_c,
	input logic [2:0]  sector
);

	localparam logic [24:0] HALF_O = 25'(64'd1 << (FRAC_BITS - 1));

	// flops only clear at the first edge when reset is applied from time zero
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(v_alpha) && $stable(v_beta))
		else $error("waiting request changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
			&& $stable(duty_c) && $stable(sector))
		else $error("stalled result changed");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sector == svpwm_pkg::SEC_ZERO |->
			duty_a == HALF_O && duty_b == HALF_O && duty_c == HALF_O)
		else $error("zero vector duties not at one half");

	a_no_sec7: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sector != svpwm_pkg::SEC_7)
		else $error("impossible sector code");

endmodule

bind space_vector_pwm_duty_top svpwm_chk #(.FRAC_BITS(FRAC_BITS)) u_svpwm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.v_alpha   (v_alpha),
	.v_beta    (v_beta),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.duty_a    (duty_a),
	.duty_b    (duty_b),
	.duty_c    (duty_c),
	.sector    (sector)
);

>>> verif/tb_space_vector_pwm_duty_top.sv
// Self-checking testbench for the space vector PWM duty generator top level.
`timescale 1ns / 1ps

module tb_space_vector_pwm_duty_top;

	localparam int FRAC = svpwm_pkg::FRAC_BITS_DEF;
	localparam int N_RANDOM = 480;
	localparam int DRAIN_CYCLES = FRAC + 16;

	typedef struct {
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
	} vec_t;

	typedef struct {
		logic [svpwm_pkg::DUTY_W-1:0] da;
		logic [svpwm_pkg::DUTY_W-1:0] db;
		logic [svpwm_pkg::DUTY_W-1:0] dc;
		logic [2:0]                   sec;
	} duty_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] v_alpha = '0;
	logic signed [31:0] v_beta = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [24:0] duty_a, duty_b, duty_c;
	logic [2:0] sector;

	vec_t pending_vecs[$];
	duty_set_t expected_duties[$];
	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_overmod = 0;
	int sector_hits[8];
	int pause_points[$];
	bit stimulus_loaded = 1'b0;

	space_vector_pwm_duty_top #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.v_alpha(v_alpha),
		.v_beta(v_beta),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.duty_a(duty_a),
		.duty_b(duty_b),
		.duty_c(duty_c),
		.sector(sector)
	);

	always #5 clk = ~clk;

	// floor((c*x) / 2^FRAC)
	function automatic longint fx_mul(longint c, longint x);
		return (c * x) >>> FRAC;
	endfunction

	// (a << FRAC) / b, truncated toward zero, b > 0
	function automatic longint fx_div(longint a, longint b);
		longint m, q;
		m = (a < 0) ? -a : a;
		q = (m <<< FRAC) / b;
		return (a < 0) ? -q : q;
	endfunction

	function automatic logic [svpwm_pkg::DUTY_W-1:0] clamp_duty(longint d, longint one);
		if (d < 0)
			return '0;
		if (d > one)
			return one[svpwm_pkg::DUTY_W-1:0];
		return d[svpwm_pkg::DUTY_W-1:0];
	endfunction

	function automatic duty_set_t predict_duties(logic signed [31:0] al_in,
			logic signed [31:0] be_in);
		longint one, half, k, al, be, x, y, z, t1, t2, sum, base;
		longint d[3];
		int p0, p1, p2;
		logic [2:0] sec;
		duty_set_t r;
		one = longint'(1) <<< FRAC;
		half = one >>> 1;
		k = longint'(svpwm_pkg::SQ3H_Q32) >> (32 - FRAC);
		al = al_in;
		be = be_in;
		sec = svpwm_pkg::SEC_ZERO;
		if (be > 0)
			sec[0] = 1'b1;
		if (fx_mul(-half, be) + fx_mul(k, al) > 0)
			sec[1] = 1'b1;
		if (fx_mul(-half, be) + fx_mul(-k, al) > 0)
			sec[2] = 1'b1;
		x = be;
		y = fx_mul(half, be) + fx_mul(k, al);
		z = fx_mul(half, be) - fx_mul(k, al);
		p0 = -1; p1 = 0; p2 = 0; t1 = 0; t2 = 0;
		d[0] = half; d[1] = half; d[2] = half;
		case (sec)
			svpwm_pkg::SEC_1: begin t1 = z;  t2 = y;  p0 = 1; p1 = 0; p2 = 2; end
			svpwm_pkg::SEC_2: begin t1 = y;  t2 = -x; p0 = 0; p1 = 2; p2 = 1; end
			svpwm_pkg::SEC_3: begin t1 = -z; t2 = x;  p0 = 0; p1 = 1; p2 = 2; end
			svpwm_pkg::SEC_4: begin t1 = -x; t2 = z;  p0 = 2; p1 = 1; p2 = 0; end
			svpwm_pkg::SEC_5: begin t1 = x;  t2 = -y; p0 = 1; p1 = 2; p2 = 0; end
			svpwm_pkg::SEC_6: begin t1 = -y; t2 = -z; p0 = 2; p1 = 0; p2 = 1; end
			default: ;
		endcase
		if (p0 >= 0) begin
			sum = t1 + t2;
			if (sum > one) begin
				t1 = fx_div(t1, sum);
				t2 = fx_div(t2, sum);
				n_overmod++;
			end
			base = fx_mul(half, one - t1 - t2);
			d[p0] = base;
			d[p1] = base + t1;
			d[p2] = d[p1] + t2;
		end
		r.da = clamp_duty(d[0], one);
		r.db = clamp_duty(d[1], one);
		r.dc = clamp_duty(d[2], one);
		r.sec = sec;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_span(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic add_vec(logic signed [31:0] a, logic signed [31:0] b);
		vec_t v;
		v.alpha = a;
		v.beta = b;
		pending_vecs.push_back(v);
	endtask

	// sender: bursts with random gaps; pauses at chosen points until drained
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		vec_t v;
		duty_set_t e;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				e = predict_duties(v_alpha, v_beta);
				expected_duties.push_back(e);
				sector_hits[e.sec]++;
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pause_points.size() > 0 && n_sent >= pause_points[0]
						&& expected_duties.size() != 0) begin
					in_valid <= 1'b0;
				end else if (stimulus_loaded && pending_vecs.size() > 0) begin
					if (pause_points.size() > 0 && n_sent >= pause_points[0])
						void'(pause_points.pop_front());
					v = pending_vecs.pop_front();
					in_valid <= 1'b1;
					v_alpha <= v.alpha;
					v_beta <= v.beta;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: alternates free-running and random stalls, one long hold-off
	int hold_left = 0;
	bit hold_done = 1'b0;
	int mode_left = 0;
	bit mode_free = 1'b1;
	always @(posedge clk) begin
		duty_set_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_duties.size() == 0) begin
					$error("unexpected result: duty_a %0d duty_b %0d duty_c %0d sector %0d",
						duty_a, duty_b, duty_c, sector);
					n_errors++;
				end else begin
					e = expected_duties.pop_front();
					if (duty_a !== e.da) begin
						$error("duty_a expected %0d actual %0d", e.da, duty_a);
						n_errors++;
					end
					if (duty_b !== e.db) begin
						$error("duty_b expected %0d actual %0d", e.db, duty_b);
						n_errors++;
					end
					if (duty_c !== e.dc) begin
						$error("duty_c expected %0d actual %0d", e.dc, duty_c);
						n_errors++;
					end
					if (sector !== e.sec) begin
						$error("sector expected %0d actual %0d", e.sec, sector);
						n_errors++;
					end
					n_checked++;
				end
			end
			if (!hold_done && n_checked >= 150) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (mode_left == 0) begin
				mode_free = $urandom_range(0, 2) == 0;
				mode_left = $urandom_range(10, 60);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (mode_free) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= $urandom_range(0, 2) != 0;
			end
		end
	end

	initial begin
		int sel;
		// directed: zero vector, field extremes, each sector, overmodulation
		add_vec(0, 0);
		add_vec(32'sh7fffffff, 32'sh7fffffff);
		add_vec(32'sh80000000, 32'sh80000000);
		add_vec(32'sh7fffffff, 32'sh80000000);
		add_vec(32'sh80000000, 32'sh7fffffff);
		add_vec(-1, -1);
		add_vec(1, 1);
		add_vec(0, 32'sh00400000);
		add_vec(32'sh00400000, 32'sh00100000);
		add_vec(32'sh00400000, -32'sh00100000);
		add_vec(-32'sh00400000, 32'sh00100000);
		add_vec(-32'sh00400000, -32'sh00100000);
		add_vec(0, -32'sh00400000);
		add_vec(32'sh01000000, 0);
		add_vec(-32'sh01000000, 0);
		add_vec(32'sh01000000, 32'sh01000000);
		add_vec(-32'sh01000000, -32'sh01000000);
		add_vec(32'sh00c00000, -32'sh00800000);
		add_vec(32'sh02000000, 32'sh00800000);
		add_vec(0, 32'sh7fffffff);
		add_vec(32'sh80000000, 0);
		pause_points.push_back(pending_vecs.size());
		for (int i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 2)
				add_vec($urandom, $urandom);
			else if (sel < 4)
				add_vec(rand_span(1 << 26), rand_span(1 << 26));
			else if (sel < 8)
				add_vec(rand_span(1 << 24), rand_span(1 << 24));
			else
				add_vec(rand_span(64), rand_span(64));
			if (i == N_RANDOM / 2)
				pause_points.push_back(pending_vecs.size());
		end
		stimulus_loaded = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_vecs.size() == 0 && !in_valid && expected_duties.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d vectors, %0d with overmodulation rescaling", n_checked,
			n_overmod);
		$display("sector counts 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
			sector_hits[4], sector_hits[5], sector_hits[6], sector_hits[7]);
		if (n_errors == 0 && expected_duties.size() == 0)
			$display("space_vector_pwm_duty_top verification clean");
		else
			$display("space_vector_pwm_duty_top verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout: %0d requests sent, %0d results checked", n_sent, n_checked);
		$display("space_vector_pwm_duty_top verification failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/svpwm_pkg.sv
hdl/svpwm_front.sv
hdl/svpwm_fifo.sv
hdl/svpwm_back.sv
hdl/space_vector_pwm_duty_top.sv
hdl/svpwm_chk.sv
verif/tb_space_vector_pwm_duty_top.sv
